### rtl/core/aagc_pkg.sv
// shared types, constants and the dB threshold table for the audio agc
// no dependencies; every other file in rtl/core imports this package

package aagc_pkg;

  // block geometry; the depths are powers of two so the averages are plain shifts
  localparam int BlockShift = 8;               // 256 samples per block
  localparam int DcDepth    = 16;
  localparam int DcAw       = $clog2(DcDepth);
  localparam int LvlDepth   = 8;
  localparam int LvlAw      = $clog2(LvlDepth);
  localparam int DbSteps    = 90;

  // register indexes on the apb port
  localparam logic [2:0] REG_AGC_ON     = 3'd0;
  localparam logic [2:0] REG_LOUD_RAISE = 3'd1;
  localparam logic [2:0] REG_LOUD_LOWER = 3'd2;
  localparam logic [2:0] REG_QUIET_RAISE = 3'd3;
  localparam logic [2:0] REG_QUIET_LOWER = 3'd4;
  localparam logic [2:0] REG_MAX_GAIN   = 3'd5;
  localparam logic [2:0] REG_CLIP_CUT   = 3'd6;

  localparam logic [5:0] UNITY_GAIN = 6'd2;

  typedef struct packed {
    logic       agc_on;
    logic [7:0] loud_raise_db;
    logic [7:0] loud_lower_db;
    logic [7:0] quiet_raise_db;
    logic [7:0] quiet_lower_db;
    logic [5:0] max_gain_halves;
    logic [5:0] clip_cut_halves;
  } cfg_t;

  // block-end unit to sample path
  typedef struct packed {
    logic [5:0]        gain;
    logic signed [19:0] dc_est;
    logic [7:0]        level_avg;
    logic              loud_mode;
    logic              busy;
    logic              done;
    logic              clear;
  } blk_ctl_t;

  // sample path to block-end unit
  typedef struct packed {
    logic        start;
    logic        adv;
    logic [31:0] block_sum;
    logic [47:0] sq_sum;
    logic        clip_seen;
  } path_stat_t;

  // variance thresholds for 24 + 10*log10(var)
  localparam logic [31:0] DB_TAB [DbSteps] = '{
    32'd2, 32'd2, 32'd2, 32'd3, 32'd4, 32'd4, 32'd6, 32'd7, 32'd8, 32'd10,
    32'd13, 32'd16, 32'd20, 32'd26, 32'd32, 32'd40, 32'd51, 32'd64, 32'd80, 32'd100,
    32'd126, 32'd159, 32'd200, 32'd252, 32'd317, 32'd399, 32'd502, 32'd631, 32'd795,
    32'd1000,
    32'd1259, 32'd1585, 32'd1996, 32'd2512, 32'd3163, 32'd3982, 32'd5012, 32'd6310,
    32'd7944, 32'd10000,
    32'd12590, 32'd15849, 32'd19953, 32'd25119, 32'd31623, 32'd39811, 32'd50119,
    32'd63096, 32'd79433, 32'd100000,
    32'd125893, 32'd158490, 32'd199527, 32'd251189, 32'd316228, 32'd398108,
    32'd501188, 32'd630958, 32'd794329, 32'd1000000,
    32'd1258926, 32'd1584894, 32'd1995263, 32'd2511887, 32'd3162278, 32'd3981072,
    32'd5011873, 32'd6309574, 32'd7943283, 32'd10000000,
    32'd12589255, 32'd15848932, 32'd19952624, 32'd25118865, 32'd31622777,
    32'd39810718, 32'd50118724, 32'd63095735, 32'd79432824, 32'd100000000,
    32'd125892542, 32'd158489320, 32'd199526232, 32'd251188644, 32'd316227767,
    32'd398107171, 32'd501187234, 32'd630957345, 32'd794328235, 32'd1000000000
  };

endpackage

### rtl/core/aagc_regs.sv
// apb configuration registers for the audio agc
// depends on aagc_pkg

module aagc_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output aagc_pkg::cfg_t       cfg
);
  import aagc_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.agc_on          <= 1'b1;
      cfg.loud_raise_db   <= 8'd50;
      cfg.loud_lower_db   <= 8'd70;
      cfg.quiet_raise_db  <= 8'd70;
      cfg.quiet_lower_db  <= 8'd90;
      cfg.max_gain_halves <= 6'd32;
      cfg.clip_cut_halves <= 6'd8;
    end else if (wr_en) begin
      unique case (idx)
        REG_AGC_ON:      cfg.agc_on          <= pwdata[0];
        REG_LOUD_RAISE:  cfg.loud_raise_db   <= pwdata[7:0];
        REG_LOUD_LOWER:  cfg.loud_lower_db   <= pwdata[7:0];
        REG_QUIET_RAISE: cfg.quiet_raise_db  <= pwdata[7:0];
        REG_QUIET_LOWER: cfg.quiet_lower_db  <= pwdata[7:0];
        REG_MAX_GAIN:    cfg.max_gain_halves <= pwdata[5:0];
        REG_CLIP_CUT:    cfg.clip_cut_halves <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_AGC_ON:      prdata = {31'd0, cfg.agc_on};
      REG_LOUD_RAISE:  prdata = {24'd0, cfg.loud_raise_db};
      REG_LOUD_LOWER:  prdata = {24'd0, cfg.loud_lower_db};
      REG_QUIET_RAISE: prdata = {24'd0, cfg.quiet_raise_db};
      REG_QUIET_LOWER: prdata = {24'd0, cfg.quiet_lower_db};
      REG_MAX_GAIN:    prdata = {26'd0, cfg.max_gain_halves};
      REG_CLIP_CUT:    prdata = {26'd0, cfg.clip_cut_halves};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/aagc_path.sv
// per-sample path: dc subtract, gain multiply, saturate, output register,
// plus the block sum, square sum and clip flag; depends on aagc_pkg

module aagc_path (
  input  logic                   clk,
  input  logic                   rst,
  input  aagc_pkg::cfg_t         cfg,
  input  aagc_pkg::blk_ctl_t     ctl,
  output aagc_pkg::path_stat_t   stat,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // [15:0] mic_sample
  input  logic                   s_tlast,   // block_end
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // [15:0] out_sample, [16] clipped,
                                            // [22:17] gain_halves, [30:23] level_db,
                                            // [31] loud_mode
  output logic                   m_tlast    // last_of_block
);
  import aagc_pkg::*;

  logic               v1, end1, v2, end2;
  logic signed [15:0] s1, s2;
  logic [5:0]         g1, g2;
  logic signed [27:0] p2;
  logic signed [20:0] d1;
  logic signed [27:0] p_next;
  logic signed [31:0] sq1;
  logic               adv, mv1, mv2, acc_in, hold_end;
  logic signed [27:0] q2;
  logic [15:0]        res2;
  logic               clip2;
  logic [31:0]        block_sum;
  logic [47:0]        sq_sum;
  logic               clip_seen;

  // handshake and stage movement
  assign adv      = !m_tvalid || m_tready;
  assign mv2      = v2 && (!end2 || ctl.done) && adv;
  assign mv1      = v1 && (!v2 || mv2);
  assign hold_end = (v1 && end1) || (v2 && end2);
  assign s_tready = (!v1 || mv1) && !hold_end;
  assign acc_in   = s_tvalid && s_tready;

  // dc removal and gain product
  assign d1     = 21'($signed({s1, 4'd0})) - 21'(ctl.dc_est);
  assign p_next = d1 * $signed({1'b0, g1});
  assign sq1    = s1 * s1;

  // saturation, truncation toward zero, raw sample when the agc is off
  always_comb begin
    q2    = (p2 < 0) ? ((p2 + 28'sd31) >>> 5) : (p2 >>> 5);
    res2  = q2[15:0];
    clip2 = 1'b0;
    if (!cfg.agc_on) begin
      res2 = s2;
    end else if (p2 > 28'sd1048544) begin
      res2  = 16'h7fff;
      clip2 = 1'b1;
    end else if (p2 < -28'sd1048576) begin
      res2  = 16'h8000;
      clip2 = 1'b1;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (acc_in) v1 <= 1'b1;
      else if (mv1) v1 <= 1'b0;
      if (mv1) v2 <= 1'b1;
      else if (mv2) v2 <= 1'b0;
      if (mv2) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1   <= s_tdata;
      end1 <= s_tlast;
      g1   <= ctl.gain;
    end
    if (mv1) begin
      s2   <= s1;
      end2 <= end1;
      g2   <= g1;
      p2   <= p_next;
    end
    if (mv2) begin
      m_tdata <= {ctl.loud_mode, ctl.level_avg, g2, clip2, res2};
      m_tlast <= end2;
    end
  end

  // block accumulators
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      block_sum <= 32'd0;
      sq_sum    <= 48'd0;
      clip_seen <= 1'b0;
    end else begin
      if (acc_in) block_sum <= block_sum + 32'($signed(s_tdata));
      if (mv1) sq_sum <= sq_sum + 48'(sq1);
      if (v2 && clip2 && !ctl.busy) clip_seen <= 1'b1;
    end
  end

  assign stat.start     = v2 && end2;
  assign stat.adv       = adv;
  assign stat.block_sum = block_sum;
  assign stat.sq_sum    = sq_sum;
  assign stat.clip_seen = clip_seen;

endmodule

### rtl/core/aagc_blk.sv
// block-end sequencer: clip cut, dc history memory, variance to dB search,
// level history memory and gain stepping; depends on aagc_pkg

module aagc_blk (
  input  logic                   clk,
  input  logic                   rst,
  input  aagc_pkg::cfg_t         cfg,
  input  aagc_pkg::path_stat_t   stat,
  output aagc_pkg::blk_ctl_t     ctl
);
  import aagc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLIP, S_MUL, S_VAR, S_SRCH, S_LVL, S_GAIN, S_OUT
  } state_t;

  state_t              state;
  logic [5:0]          gain_reg;
  logic                mode_reg;
  logic signed [23:0]  dc_acc;
  logic [DcAw-1:0]     dc_slot;
  logic [DcDepth-1:0]  dc_vld;
  logic [10:0]         lvl_acc;
  logic [LvlAw-1:0]    lvl_slot;
  logic [LvlDepth-1:0] lvl_vld;
  logic [7:0]          level_avg;
  logic signed [19:0]  mean_r;
  logic [31:0]         mag_r;
  logic [63:0]         bb;
  logic [39:0]         var_r;
  logic [6:0]          lo;
  logic [2:0]          bit_i;

  logic signed [19:0]  dc_mem [DcDepth];
  logic [7:0]          lvl_mem [LvlDepth];
  logic signed [19:0]  rd_dc;
  logic                rd_dc_v;
  logic [7:0]          rd_lvl;
  logic                rd_lvl_v;

  logic signed [31:0]  sum_s;
  logic signed [27:0]  mean_w;
  logic signed [19:0]  mean_sat;
  logic [31:0]         mag_w;
  logic signed [19:0]  old_dc;
  logic [63:0]         aa;
  logic [6:0]          cand;
  logic [6:0]          tab_idx;
  logic                hit;
  logic [7:0]          db;
  logic [7:0]          old_lvl;
  logic [5:0]          maxg;
  logic [6:0]          cut_lim;
  logic [7:0]          lvl;
  logic [5:0]          ga, gb, gc;
  logic                mode_n;

  // block mean and magnitude of the raw sum
  always_comb begin
    sum_s  = $signed(stat.block_sum);
    mean_w = 28'(sum_s >>> 4);
    if (mean_w > 28'sd524287)       mean_sat = 20'sd524287;
    else if (mean_w < -28'sd524288) mean_sat = -20'sd524288;
    else                            mean_sat = mean_w[19:0];
    mag_w = sum_s[31] ? (32'd0 - stat.block_sum) : stat.block_sum;
  end

  // memory outputs, unwritten entries read as zero
  assign old_dc  = rd_dc_v ? rd_dc : 20'sd0;
  assign old_lvl = rd_lvl_v ? rd_lvl : 8'd0;

  // variance numerator, threshold search step
  assign aa      = {stat.sq_sum, 16'd0} >> (16 - BlockShift);
  assign cand    = lo + (7'd1 << bit_i);
  assign tab_idx = (cand <= 7'(DbSteps)) ? (cand - 7'd1) : 7'd0;
  assign hit     = (cand <= 7'(DbSteps)) && ({8'd0, DB_TAB[tab_idx]} <= var_r);
  assign db      = (var_r == 40'd0) ? 8'd0 : ({1'b0, lo} + 8'd24);

  // gain stepping with hysteresis
  always_comb begin
    maxg    = (cfg.max_gain_halves < UNITY_GAIN) ? UNITY_GAIN : cfg.max_gain_halves;
    cut_lim = {1'b0, cfg.clip_cut_halves} + 7'd2;
    lvl     = lvl_acc[10:3];
    mode_n  = mode_reg;
    ga      = gain_reg;
    if (!mode_reg) begin
      if (lvl < cfg.quiet_raise_db && ga < maxg) ga = ga + 6'd1;
      gb = ga;
      if (lvl > cfg.quiet_lower_db && gb > UNITY_GAIN) gb = gb - 6'd1;
      if (lvl > cfg.quiet_lower_db && gb == UNITY_GAIN) mode_n = 1'b1;
    end else begin
      if (lvl < cfg.loud_raise_db && ga < maxg) ga = ga + 6'd1;
      gb = ga;
      if (lvl > cfg.loud_lower_db && gb > UNITY_GAIN) gb = gb - 6'd1;
      if (lvl < cfg.loud_raise_db && gb >= maxg) mode_n = 1'b0;
    end
    gc = gb;
    if (gc > maxg) gc = maxg;
    if (gc < UNITY_GAIN) gc = UNITY_GAIN;
  end

  // history memories: read in the clip step, dc entry written in the mul step, level entry in the lvl step
  always_ff @(posedge clk) begin
    if (state == S_CLIP) begin
      rd_dc  <= dc_mem[dc_slot];
      rd_lvl <= lvl_mem[lvl_slot];
    end
    if (state == S_MUL) dc_mem[dc_slot] <= mean_r;
    if (state == S_LVL) lvl_mem[lvl_slot] <= db;
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gain_reg  <= UNITY_GAIN;
      mode_reg  <= 1'b1;
      dc_acc    <= 24'sd0;
      dc_slot   <= '0;
      dc_vld    <= '0;
      lvl_acc   <= 11'd0;
      lvl_slot  <= '0;
      lvl_vld   <= '0;
      level_avg <= 8'd120;
      rd_dc_v   <= 1'b0;
      rd_lvl_v  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (stat.start) state <= S_CLIP;
        end
        S_CLIP: begin
          if (cfg.agc_on && stat.clip_seen) begin
            mode_reg <= 1'b1;
            gain_reg <= ({1'b0, gain_reg} > cut_lim) ? (gain_reg - cfg.clip_cut_halves)
                                                     : UNITY_GAIN;
          end
          mean_r   <= mean_sat;
          mag_r    <= mag_w;
          rd_dc_v  <= dc_vld[dc_slot];
          rd_lvl_v <= lvl_vld[lvl_slot];
          state    <= S_MUL;
        end
        S_MUL: begin
          bb              <= mag_r * mag_r;
          dc_acc          <= dc_acc - 24'(old_dc) + 24'(mean_r);
          dc_vld[dc_slot] <= 1'b1;
          dc_slot         <= dc_slot + 1'b1;
          state           <= S_VAR;
        end
        S_VAR: begin
          var_r <= (aa > bb) ? 40'((aa - bb) >> (2 * BlockShift)) : 40'd0;
          lo    <= 7'd0;
          bit_i <= 3'd6;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (hit) lo <= cand;
          if (bit_i == 3'd0) state <= S_LVL;
          else bit_i <= bit_i - 3'd1;
        end
        S_LVL: begin
          lvl_acc           <= lvl_acc - 11'(old_lvl) + 11'(db);
          lvl_vld[lvl_slot] <= 1'b1;
          lvl_slot          <= lvl_slot + 1'b1;
          state             <= S_GAIN;
        end
        S_GAIN: begin
          level_avg <= lvl;
          gain_reg  <= gc;
          mode_reg  <= mode_n;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (stat.adv) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ctl.gain      = gain_reg;
  assign ctl.dc_est    = dc_acc[23:4];
  assign ctl.level_avg = level_avg;
  assign ctl.loud_mode = mode_reg;
  assign ctl.busy      = (state != S_IDLE);
  assign ctl.done      = (state == S_OUT);
  assign ctl.clear     = (state == S_GAIN);

  // checks
  a_gain_floor: assert property (@(posedge clk) disable iff (rst)
    gain_reg >= UNITY_GAIN)
    else $error("gain below unity");

  a_start_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_CLIP |-> $past(state) == S_IDLE && $past(stat.start))
    else $error("block sequence entered without a block end");

  a_dc_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> dc_slot == $past(dc_slot) + 1'b1)
    else $error("dc slot not advanced");

  a_gain_out: assert property (@(posedge clk) disable iff (rst)
    state == S_GAIN |=> state == S_OUT)
    else $error("gain step not followed by output");

endmodule

### rtl/core/audio_agc_with_dc_removal.sv
// audio agc with dc removal: ordinary samples pass through the input, product and output
// registers, and one sample is taken every cycle while the output is not stalled.
// a sample marked block end holds the input while the block sequencer runs
// (clip cut, dc history, 7-step dB search, gain step).
// synchronous active-high reset; history memories read as zero until written,
// so no clearing pass is needed. depends on aagc_pkg, aagc_regs, aagc_path, aagc_blk

module audio_agc_with_dc_removal (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [15:0] mic_sample
  input  logic        s_tlast,    // block_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [15:0] out_sample, [16] clipped, [22:17] gain_halves,
                                  // [30:23] level_db, [31] loud_mode
  output logic        m_tlast,    // last_of_block
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import aagc_pkg::*;

  cfg_t       cfg;
  blk_ctl_t   ctl;
  path_stat_t stat;

  aagc_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  aagc_path u_path (
    .clk(clk), .rst(rst), .cfg(cfg), .ctl(ctl), .stat(stat),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  aagc_blk u_blk (
    .clk(clk), .rst(rst), .cfg(cfg), .stat(stat), .ctl(ctl)
  );

endmodule
